FILE: rtl/allele_counts_to_pomo_state_defines.svh
// assertion macros shared by the checker of allele_counts_to_pomo_state
// needs signals named clock and reset in the scope of use
`ifndef ALLELE_COUNTS_TO_POMO_STATE_DEFINES_SVH
`define ALLELE_COUNTS_TO_POMO_STATE_DEFINES_SVH

// same-cycle implication, off during reset
`define ACP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acp check failed");

// next-cycle implication, off during reset
`define ACP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acp check failed");

// next-cycle implication that also holds across reset
`define ACP_ASSERT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("acp check failed");

`endif

FILE: rtl/acp_pkg.sv
// shared constants, types and helpers for allele_counts_to_pomo_state
// no dependencies
package acp_pkg;

   localparam int MAX_POP    = 16;
   localparam int COUNT_BITS = 8;
   localparam int NUM_COUNTS = 5;
   localparam int NUM_BASES  = 4;
   localparam int NUM_PAIRS  = 6;
   localparam int NUM_CAND   = NUM_BASES + NUM_PAIRS;
   localparam int GAP_IDX    = 4;

   localparam int POP_BITS   = 5;
   localparam int POP_RESET  = 10;
   localparam int STATE_BITS = 7;
   localparam int MAX_STATE  = NUM_BASES + NUM_PAIRS * (MAX_POP - 1);

   localparam int N_BITS   = $clog2(MAX_POP + 1);
   localparam int S_BITS   = COUNT_BITS + 3;
   localparam int SN_BITS  = S_BITS + N_BITS;
   localparam int DP_BITS  = COUNT_BITS + N_BITS + 1;
   localparam int LHS_BITS = S_BITS + N_BITS + 3;
   localparam int A_BITS   = 2 * N_BITS + 1;
   localparam int B_BITS   = COUNT_BITS + N_BITS + 1;
   localparam int SA_BITS  = S_BITS + A_BITS;
   localparam int NB_BITS  = N_BITS + B_BITS;
   localparam int F_BITS   = SA_BITS + 2;

   localparam logic [STATE_BITS-1:0] STATE_ALL_GAP = STATE_BITS'(0);
   localparam logic [STATE_BITS-1:0] STATE_ZERO    = STATE_BITS'(1);

   typedef struct packed {
      logic                     ok;
      logic signed [F_BITS-1:0] f;
      logic [STATE_BITS-1:0]    row;
   } cand_type;

   function automatic int pair_first(input int p);
      int r;
      case (p)
         0, 1, 2: r = 0;
         3, 4:    r = 1;
         default: r = 2;
      endcase
      return r;
   endfunction

   function automatic int pair_second(input int p);
      int r;
      case (p)
         0:       r = 1;
         1, 3:    r = 2;
         default: r = 3;
      endcase
      return r;
   endfunction

   // later candidate wins if valid and strictly smaller, or if the earlier one is not valid
   function automatic cand_type pick(input cand_type x, input cand_type y);
      cand_type r;
      r = x;
      if (y.ok && (!x.ok || (y.f < x.f))) begin
         r = y;
      end
      return r;
   endfunction

endpackage

FILE: rtl/allele_counts_to_pomo_state.sv
// throughput: one item per cycle; each stage holds while the next is full
// stages: sum, products, crossing count, pattern terms, scaled terms,
// distance, two-level minimum tree with output register
// reset clears all stage valid bits and sets pop_size to 10
module allele_counts_to_pomo_state (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [acp_pkg::COUNT_BITS-1:0]     req_count_a,
   input  logic [acp_pkg::COUNT_BITS-1:0]     req_count_c,
   input  logic [acp_pkg::COUNT_BITS-1:0]     req_count_g,
   input  logic [acp_pkg::COUNT_BITS-1:0]     req_count_t,
   input  logic [acp_pkg::COUNT_BITS-1:0]     req_count_gap,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [acp_pkg::STATE_BITS-1:0]     rsp_state_index,
   input  logic                               csr_wr_en,
   input  logic [acp_pkg::POP_BITS-1:0]       csr_wr_data
);

   localparam int NST = 8;

   logic [acp_pkg::POP_BITS-1:0] pop_ff;
   logic [NST:1] vld_ff;
   logic [NST:1] en;

   // stage 1
   logic [acp_pkg::COUNT_BITS-1:0] c1_ff [acp_pkg::NUM_COUNTS];
   logic [acp_pkg::S_BITS-1:0]     s1_ff;
   logic [acp_pkg::N_BITS-1:0]     n1_ff;
   logic                           zero1_ff, gap1_ff;
   logic [acp_pkg::S_BITS-1:0]     s1_in;
   logic [acp_pkg::N_BITS-1:0]     n1_in;
   logic [acp_pkg::COUNT_BITS-1:0] cin [acp_pkg::NUM_COUNTS];

   // stage 2
   logic [acp_pkg::COUNT_BITS-1:0]    c2_ff [acp_pkg::NUM_COUNTS];
   logic [acp_pkg::S_BITS-1:0]        s2_ff;
   logic [acp_pkg::N_BITS-1:0]        n2_ff;
   logic                              zero2_ff, gap2_ff;
   logic [acp_pkg::SN_BITS-1:0]       sn2_ff;
   logic signed [acp_pkg::DP_BITS-1:0] dp2_ff [acp_pkg::NUM_PAIRS];
   logic [acp_pkg::A_BITS-1:0]        nsq2_ff;
   logic [acp_pkg::B_BITS-1:0]        bf2_ff [acp_pkg::NUM_BASES];

   // stage 3
   logic [acp_pkg::COUNT_BITS-1:0] c3_ff [acp_pkg::NUM_COUNTS];
   logic [acp_pkg::S_BITS-1:0]     s3_ff;
   logic [acp_pkg::N_BITS-1:0]     n3_ff;
   logic                           zero3_ff, gap3_ff;
   logic [acp_pkg::N_BITS-1:0]     kb3_ff [acp_pkg::NUM_PAIRS];
   logic [acp_pkg::N_BITS-1:0]     kb3_in [acp_pkg::NUM_PAIRS];
   logic [acp_pkg::A_BITS-1:0]     nsq3_ff;
   logic [acp_pkg::B_BITS-1:0]     bf3_ff [acp_pkg::NUM_BASES];

   // stage 4
   logic [acp_pkg::S_BITS-1:0]     s4_ff;
   logic [acp_pkg::N_BITS-1:0]     n4_ff;
   logic                           zero4_ff, gap4_ff;
   logic [acp_pkg::A_BITS-1:0]     a4_ff [acp_pkg::NUM_CAND];
   logic [acp_pkg::B_BITS-1:0]     b4_ff [acp_pkg::NUM_CAND];
   logic [acp_pkg::STATE_BITS-1:0] row4_ff [acp_pkg::NUM_CAND];
   logic [acp_pkg::NUM_CAND-1:0]   ok4_ff;
   logic [acp_pkg::A_BITS-1:0]     a4_in [acp_pkg::NUM_CAND];
   logic [acp_pkg::B_BITS-1:0]     b4_in [acp_pkg::NUM_CAND];
   logic [acp_pkg::STATE_BITS-1:0] row4_in [acp_pkg::NUM_CAND];
   logic [acp_pkg::NUM_CAND-1:0]   ok4_in;

   // stage 5
   logic                           zero5_ff, gap5_ff;
   logic [acp_pkg::SA_BITS-1:0]    sa5_ff [acp_pkg::NUM_CAND];
   logic [acp_pkg::NB_BITS-1:0]    nb5_ff [acp_pkg::NUM_CAND];
   logic [acp_pkg::STATE_BITS-1:0] row5_ff [acp_pkg::NUM_CAND];
   logic [acp_pkg::NUM_CAND-1:0]   ok5_ff;

   // stage 6
   logic                  zero6_ff, gap6_ff;
   acp_pkg::cand_type     cd6_ff [acp_pkg::NUM_CAND];

   // stage 7
   logic                  zero7_ff, gap7_ff;
   acp_pkg::cand_type     g7_ff [3];
   acp_pkg::cand_type     g7_in [3];

   // stage 8
   logic [acp_pkg::STATE_BITS-1:0] state8_ff;
   logic [acp_pkg::STATE_BITS-1:0] state8_in;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      en[NST] = !vld_ff[NST] || rsp_ready;
      for (int i = NST - 1; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_ready       = en[1];
   assign rsp_valid       = vld_ff[NST];
   assign rsp_state_index = state8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         pop_ff <= acp_pkg::POP_BITS'(acp_pkg::POP_RESET);
      end else begin
         if (csr_wr_en) begin
            pop_ff <= csr_wr_data;
         end
         if (en[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NST; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // ---- stage 1: total and clamped population size
   assign cin[0] = req_count_a;
   assign cin[1] = req_count_c;
   assign cin[2] = req_count_g;
   assign cin[3] = req_count_t;
   assign cin[4] = req_count_gap;

   always_comb begin
      s1_in = '0;
      for (int i = 0; i < acp_pkg::NUM_COUNTS; i++) begin
         s1_in = s1_in + acp_pkg::S_BITS'(cin[i]);
      end
      if (pop_ff == '0) begin
         n1_in = acp_pkg::N_BITS'(1);
      end else if (acp_pkg::N_BITS'(pop_ff) > acp_pkg::N_BITS'(acp_pkg::MAX_POP)) begin
         n1_in = acp_pkg::N_BITS'(acp_pkg::MAX_POP);
      end else begin
         n1_in = acp_pkg::N_BITS'(pop_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c1_ff    <= cin;
         s1_ff    <= s1_in;
         n1_ff    <= n1_in;
         zero1_ff <= (s1_in == '0);
         gap1_ff  <= (s1_in == acp_pkg::S_BITS'(req_count_gap));
      end
   end

   // ---- stage 2: S*N, N*(cp-cq), N*N, N*c
   always_ff @(posedge clock) begin
      if (en[2]) begin
         c2_ff    <= c1_ff;
         s2_ff    <= s1_ff;
         n2_ff    <= n1_ff;
         zero2_ff <= zero1_ff;
         gap2_ff  <= gap1_ff;
         sn2_ff   <= acp_pkg::SN_BITS'(s1_ff) * acp_pkg::SN_BITS'(n1_ff);
         nsq2_ff  <= acp_pkg::A_BITS'(n1_ff) * acp_pkg::A_BITS'(n1_ff);
         for (int p = 0; p < acp_pkg::NUM_PAIRS; p++) begin
            dp2_ff[p] <= acp_pkg::DP_BITS'($signed({1'b0, acp_pkg::DP_BITS'(n1_ff)})
                         * ($signed({1'b0, acp_pkg::DP_BITS'(c1_ff[acp_pkg::pair_first(p)])})
                         - $signed({1'b0, acp_pkg::DP_BITS'(c1_ff[acp_pkg::pair_second(p)])})))
                         ;
         end
         for (int i = 0; i < acp_pkg::NUM_BASES; i++) begin
            bf2_ff[i] <= acp_pkg::B_BITS'(n1_ff) * acp_pkg::B_BITS'(c1_ff[i]);
         end
      end
   end

   // ---- stage 3: best k per pair, from the sign of f(k+1)-f(k)
   // f(k+1) < f(k) while S*(2k+1) - S*N < N*(cp-cq)
   always_comb begin
      logic [acp_pkg::LHS_BITS-1:0]        t;
      logic signed [acp_pkg::LHS_BITS-1:0] lhs;
      logic [acp_pkg::N_BITS-1:0]          cnt;
      for (int p = 0; p < acp_pkg::NUM_PAIRS; p++) begin
         cnt = '0;
         for (int k = 1; k <= acp_pkg::MAX_POP - 2; k++) begin
            t   = acp_pkg::LHS_BITS'(s2_ff) * acp_pkg::LHS_BITS'(2 * k + 1);
            lhs = $signed(t) - $signed(acp_pkg::LHS_BITS'(sn2_ff));
            if ((acp_pkg::N_BITS'(k + 2) <= n2_ff)
                && (lhs < acp_pkg::LHS_BITS'(dp2_ff[p]))) begin
               cnt = cnt + acp_pkg::N_BITS'(1);
            end
         end
         kb3_in[p] = cnt + acp_pkg::N_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         c3_ff    <= c2_ff;
         s3_ff    <= s2_ff;
         n3_ff    <= n2_ff;
         zero3_ff <= zero2_ff;
         gap3_ff  <= gap2_ff;
         kb3_ff   <= kb3_in;
         nsq3_ff  <= nsq2_ff;
         bf3_ff   <= bf2_ff;
      end
   end

   // ---- stage 4: per candidate terms a and b of f = S*a - 2N*b
   always_comb begin
      logic [acp_pkg::N_BITS-1:0] kk, nk;
      for (int i = 0; i < acp_pkg::NUM_BASES; i++) begin
         a4_in[i]   = nsq3_ff;
         b4_in[i]   = bf3_ff[i];
         row4_in[i] = acp_pkg::STATE_BITS'(i);
         ok4_in[i]  = 1'b1;
      end
      for (int p = 0; p < acp_pkg::NUM_PAIRS; p++) begin
         kk = kb3_ff[p];
         nk = n3_ff - kk;
         a4_in[acp_pkg::NUM_BASES+p] = acp_pkg::A_BITS'(kk) * acp_pkg::A_BITS'(kk)
                                     + acp_pkg::A_BITS'(nk) * acp_pkg::A_BITS'(nk);
         b4_in[acp_pkg::NUM_BASES+p] =
            acp_pkg::B_BITS'(kk) * acp_pkg::B_BITS'(c3_ff[acp_pkg::pair_first(p)])
            + acp_pkg::B_BITS'(nk) * acp_pkg::B_BITS'(c3_ff[acp_pkg::pair_second(p)]);
         row4_in[acp_pkg::NUM_BASES+p] = acp_pkg::STATE_BITS'(acp_pkg::NUM_BASES)
            + acp_pkg::STATE_BITS'(p) * acp_pkg::STATE_BITS'(n3_ff - acp_pkg::N_BITS'(1))
            + acp_pkg::STATE_BITS'(kk) - acp_pkg::STATE_BITS'(1);
         ok4_in[acp_pkg::NUM_BASES+p] = (n3_ff > acp_pkg::N_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_ff    <= s3_ff;
         n4_ff    <= n3_ff;
         zero4_ff <= zero3_ff;
         gap4_ff  <= gap3_ff;
         a4_ff    <= a4_in;
         b4_ff    <= b4_in;
         row4_ff  <= row4_in;
         ok4_ff   <= ok4_in;
      end
   end

   // ---- stage 5: scaled terms
   always_ff @(posedge clock) begin
      if (en[5]) begin
         zero5_ff <= zero4_ff;
         gap5_ff  <= gap4_ff;
         row5_ff  <= row4_ff;
         ok5_ff   <= ok4_ff;
         for (int i = 0; i < acp_pkg::NUM_CAND; i++) begin
            sa5_ff[i] <= acp_pkg::SA_BITS'(s4_ff) * acp_pkg::SA_BITS'(a4_ff[i]);
            nb5_ff[i] <= acp_pkg::NB_BITS'(n4_ff) * acp_pkg::NB_BITS'(b4_ff[i]);
         end
      end
   end

   // ---- stage 6: relative distance
   always_ff @(posedge clock) begin
      if (en[6]) begin
         zero6_ff <= zero5_ff;
         gap6_ff  <= gap5_ff;
         for (int i = 0; i < acp_pkg::NUM_CAND; i++) begin
            cd6_ff[i].ok  <= ok5_ff[i];
            cd6_ff[i].row <= row5_ff[i];
            cd6_ff[i].f   <= $signed(acp_pkg::F_BITS'(sa5_ff[i]))
                             - $signed(acp_pkg::F_BITS'({nb5_ff[i], 1'b0}));
         end
      end
   end

   // ---- stage 7: fixed rows, first three pairs, last three pairs
   always_comb begin
      g7_in[0] = acp_pkg::pick(acp_pkg::pick(cd6_ff[0], cd6_ff[1]),
                               acp_pkg::pick(cd6_ff[2], cd6_ff[3]));
      g7_in[1] = acp_pkg::pick(acp_pkg::pick(cd6_ff[4], cd6_ff[5]), cd6_ff[6]);
      g7_in[2] = acp_pkg::pick(acp_pkg::pick(cd6_ff[7], cd6_ff[8]), cd6_ff[9]);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         zero7_ff <= zero6_ff;
         gap7_ff  <= gap6_ff;
         g7_ff    <= g7_in;
      end
   end

   // ---- stage 8: final pick and special sites
   always_comb begin
      acp_pkg::cand_type w;
      w = acp_pkg::pick(acp_pkg::pick(g7_ff[0], g7_ff[1]), g7_ff[2]);
      if (zero7_ff) begin
         state8_in = acp_pkg::STATE_ZERO;
      end else if (gap7_ff) begin
         state8_in = acp_pkg::STATE_ALL_GAP;
      end else begin
         state8_in = w.row + acp_pkg::STATE_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         state8_ff <= state8_in;
      end
   end

endmodule

FILE: rtl/acp_checker.sv
// port-level checks for allele_counts_to_pomo_state, bound to the top level
// depends on acp_pkg and allele_counts_to_pomo_state_defines.svh
`include "allele_counts_to_pomo_state_defines.svh"

module acp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [acp_pkg::STATE_BITS-1:0] rsp_state_index
);

   // a stalled result holds its value
   `ACP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_state_index))

   // no state beyond the last pair row
   `ACP_ASSERT_NOW(a_state_range, rsp_valid, rsp_state_index <= acp_pkg::STATE_BITS'(acp_pkg::MAX_STATE))

   // reset empties the pipeline
   `ACP_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid && req_ready)

endmodule

bind allele_counts_to_pomo_state acp_checker u_acp_checker (.*);
